// File: design/sdf_pkg.sv
// Shared types and constants for the signed decimal formatter.
package sdf_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SIGN_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ALIGN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION_GIVEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_PRECISION = 3'd4;

    // The fourth sign mode code is unused and behaves as no flag.
    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_SPACE = 2'd1;
    localparam logic [1:0] SIGN_PLUS  = 2'd2;
    localparam logic [1:0] SIGN_RSVD  = 2'd3;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] ASCII_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_NORM = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    // Commands from the sequencer to the BCD shift unit.
    typedef struct packed {
        logic load;
        logic step;
        logic shift;
    } dabble_cmd_t;

endpackage

// File: design/sdf_dabble.sv
// Shift-and-add-three binary to BCD unit with a digit shifter for output.
module sdf_dabble #(
    parameter int VALUE_BITS = 32,
    parameter int NDIG       = 10
) (
    input  logic                     clk,
    input  sdf_pkg::dabble_cmd_t     cmd,
    input  logic [VALUE_BITS-1:0]    mag,
    output logic [3:0]               top_digit
);
    import sdf_pkg::*;

    logic [VALUE_BITS-1:0] bin_reg;
    logic [VALUE_BITS-1:0] bin_next;
    logic [4*NDIG-1:0]     bcd_reg;
    logic [4*NDIG-1:0]     bcd_next;
    logic [4*NDIG-1:0]     bcd_adj;

    // Every digit of five or more gets three added before the left shift.
    always_comb
    begin
        for (int d = 0; d < NDIG; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (cmd.load)
        begin
            bin_next = mag;
            bcd_next = '0;
        end
        else if (cmd.step)
        begin
            bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
            bcd_next = {bcd_adj[4*NDIG-2:0], bin_reg[VALUE_BITS-1]};
        end
        else if (cmd.shift)
        begin
            bcd_next = {bcd_reg[4*NDIG-5:0], 4'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[4*NDIG-1 -: 4];

endmodule

// File: design/signed_decimal_formatter.sv
// Top level of the signed decimal formatter: sequencer, configuration and output register.
//
// Channel   Direction  Beat contents
// s_*       in         tdata[31:0] value (two's complement)
// m_*       out        tdata[7:0] out_char, tlast marks the final character
// cfg_*     in         cfg_index selects the register, cfg_data carries its value
//
// An accepted value passes through the BCD unit one bit per cycle until all VALUE_BITS bits
// are in; leading zero digits are then dropped one per cycle, keeping at least one digit,
// and a further step sizes the padding. One character per cycle follows while m_tready is
// high. s_tready is high only when idle; an output stall holds the character in the output
// register and pauses the emission step. Reset clears the sequencer, out valid and config.
module signed_decimal_formatter #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sdf_pkg::VALUE_W-1:0]          s_tdata,   // [31:0] value
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sdf_pkg::CHAR_W-1:0]           m_tdata,   // [7:0] out_char
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sdf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sdf_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import sdf_pkg::*;

    // Decimal digits needed for the largest magnitude.
    localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int ND_W = $clog2(NDIG + 1);
    localparam int BC_W = $clog2(VALUE_BITS + 1);

    // Configuration registers.
    logic [1:0] sign_mode_reg;
    logic       left_align_reg;
    logic [5:0] field_width_reg;
    logic       precision_given_reg;
    logic [5:0] digit_precision_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sign_mode_reg       <= '0;
            left_align_reg      <= 1'b0;
            field_width_reg     <= '0;
            precision_given_reg <= 1'b0;
            digit_precision_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SIGN_MODE:       sign_mode_reg       <= cfg_data[1:0];
                CFG_LEFT_ALIGN:      left_align_reg      <= cfg_data[0];
                CFG_FIELD_WIDTH:     field_width_reg     <= cfg_data;
                CFG_PRECISION_GIVEN: precision_given_reg <= cfg_data[0];
                CFG_DIGIT_PRECISION: digit_precision_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Input resizing: the low VALUE_BITS bits are used, zero-extended when
    // VALUE_BITS exceeds the port width.
    logic [VALUE_BITS+VALUE_W-1:0] wide_in;
    logic [VALUE_BITS-1:0]         raw;
    logic                          raw_neg;
    logic [VALUE_BITS-1:0]         mag;

    assign wide_in = {{VALUE_BITS{1'b0}}, s_tdata};
    assign raw     = wide_in[VALUE_BITS-1:0];
    assign raw_neg = raw[VALUE_BITS-1];
    assign mag     = raw_neg ? (~raw + 1'b1) : raw;

    // Sequencer state.
    state_t            state_reg,       state_next;
    logic [BC_W-1:0]   bit_cnt_reg,     bit_cnt_next;
    logic [ND_W-1:0]   ndig_reg,        ndig_next;
    logic [5:0]        zeros_cnt_reg,   zeros_cnt_next;
    logic [5:0]        spaces_cnt_reg,  spaces_cnt_next;
    logic              sign_pend_reg,   sign_pend_next;
    logic              neg_reg,         neg_next;
    logic              nonzero_reg,     nonzero_next;
    logic [CHAR_W-1:0] sign_char_reg,   sign_char_next;

    // Output register.
    logic              out_valid_reg,   out_valid_next;
    logic [CHAR_W-1:0] out_char_reg,    out_char_next;
    logic              out_last_reg,    out_last_next;

    dabble_cmd_t cmd;
    logic [3:0]  top_digit;
    logic        advance;
    logic        digit_phase;

    // Padding arithmetic on seven bits so that the differences never wrap.
    logic [6:0] ndig7;
    logic [6:0] text7;
    logic       has_sign;

    sdf_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_dabble (
        .clk       (clk),
        .cmd       (cmd),
        .mag       (mag),
        .top_digit (top_digit)
    );

    assign s_tready    = (state_reg == ST_IDLE);
    assign advance     = !out_valid_reg || m_tready;
    assign digit_phase = !sign_pend_reg && (zeros_cnt_reg == '0) && (ndig_reg != '0);

    assign has_sign = neg_reg || (nonzero_reg && (sign_mode_reg inside {SIGN_SPACE, SIGN_PLUS}));
    assign ndig7    = 7'(ndig_reg);
    assign text7    = ndig7 + 7'(has_sign);

    always_comb
    begin
        state_next      = state_reg;
        bit_cnt_next    = bit_cnt_reg;
        ndig_next       = ndig_reg;
        zeros_cnt_next  = zeros_cnt_reg;
        spaces_cnt_next = spaces_cnt_reg;
        sign_pend_next  = sign_pend_reg;
        neg_next        = neg_reg;
        nonzero_next    = nonzero_reg;
        sign_char_next  = sign_char_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        cmd             = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load     = 1'b1;
                    neg_next     = raw_neg;
                    nonzero_next = (raw != '0);
                    bit_cnt_next = BC_W'(VALUE_BITS);
                    ndig_next    = ND_W'(NDIG);
                    state_next   = ST_CONV;
                end
            end

            ST_CONV:
            begin
                cmd.step     = 1'b1;
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BC_W'(1))
                    state_next = ST_NORM;
            end

            ST_NORM:
            begin
                // Drop leading zero digits, keeping at least one digit.
                if (top_digit == 4'd0 && ndig_reg > ND_W'(1))
                begin
                    cmd.shift = 1'b1;
                    ndig_next = ndig_reg - 1'b1;
                end
                else
                begin
                    sign_pend_next  = has_sign;
                    if (neg_reg)
                        sign_char_next = ASCII_MINUS;
                    else if (sign_mode_reg == SIGN_PLUS)
                        sign_char_next = ASCII_PLUS;
                    else
                        sign_char_next = ASCII_SPACE;
                    zeros_cnt_next  = '0;
                    spaces_cnt_next = '0;
                    if (precision_given_reg)
                    begin
                        if (7'(digit_precision_reg) > ndig7)
                            zeros_cnt_next = 6'(7'(digit_precision_reg) - ndig7);
                    end
                    else if (7'(field_width_reg) > text7)
                    begin
                        if (left_align_reg)
                            spaces_cnt_next = 6'(7'(field_width_reg) - text7);
                        else
                            zeros_cnt_next  = 6'(7'(field_width_reg) - text7);
                    end
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b0;
                    if (sign_pend_reg)
                    begin
                        out_char_next  = sign_char_reg;
                        sign_pend_next = 1'b0;
                    end
                    else if (zeros_cnt_reg != '0)
                    begin
                        out_char_next  = ASCII_ZERO;
                        zeros_cnt_next = zeros_cnt_reg - 1'b1;
                    end
                    else if (ndig_reg != '0)
                    begin
                        out_char_next = ASCII_ZERO + CHAR_W'(top_digit);
                        cmd.shift     = 1'b1;
                        ndig_next     = ndig_reg - 1'b1;
                        if (ndig_reg == ND_W'(1) && spaces_cnt_reg == '0)
                        begin
                            out_last_next = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    else
                    begin
                        out_char_next   = ASCII_SPACE;
                        spaces_cnt_next = spaces_cnt_reg - 1'b1;
                        if (spaces_cnt_reg == 6'd1)
                        begin
                            out_last_next = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bit_cnt_reg    <= '0;
            ndig_reg       <= '0;
            zeros_cnt_reg  <= '0;
            spaces_cnt_reg <= '0;
            sign_pend_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bit_cnt_reg    <= bit_cnt_next;
            ndig_reg       <= ndig_next;
            zeros_cnt_reg  <= zeros_cnt_next;
            spaces_cnt_reg <= spaces_cnt_next;
            sign_pend_reg  <= sign_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg       <= neg_next;
        nonzero_reg   <= nonzero_next;
        sign_char_reg <= sign_char_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    // An accepted value always starts the conversion loop.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_CONV))
        else $error("accepted value did not start conversion");

    // Normalisation only begins once every input bit has been shifted in.
    a_norm_after_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NORM) |-> (bit_cnt_reg == '0))
        else $error("normalisation started with bits still pending");

    // While emitting, digits or trailing spaces always remain to be sent.
    a_emit_work_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (ndig_reg != '0 || spaces_cnt_reg != '0))
        else $error("emission running with nothing left");

    // The BCD unit must only hold proper decimal digits when they are sent.
    a_digit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && digit_phase) |-> (top_digit <= 4'd9))
        else $error("BCD digit out of range");

endmodule
